>>> src/smr_pkg.sv
// Shared types and constants for the mean and RMS accumulator.
package smr_pkg;

    localparam int SAMPLE_W   = 16;  // Q8.8 sample width
    localparam int MEAN_W     = 16;  // Q8.8 mean width
    localparam int ROOT_W     = 16;  // Q8.8 rms width, root bits
    localparam int COUNT_W    = 8;   // count field width
    localparam int PROD_W     = 31;  // one square, at most 2**30
    localparam int ROOT_IN_W  = 32;  // radicand width, two bits per root step
    localparam int ROOT_REM_W = 20;  // partial remainder of the root

    typedef enum logic [2:0] {
        ST_RUN,
        ST_START,
        ST_DIV,
        ST_ROOT_START,
        ST_ROOT,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic ready;      // take samples
        logic load_div;   // latch totals into the dividers, clear totals
        logic step_div;   // one quotient bit
        logic load_root;  // latch mean square into the root unit
        logic step_root;  // one root bit
        logic load_out;   // write the result register
    } t_cmd;

    typedef struct packed {
        logic last_in_stage;  // last sample of a run is being accumulated
        logic out_free;       // result register can take a new result
    } t_status;

endpackage

>>> src/smr_ctrl.sv
// Sequencer for accumulation, division and square root.
module smr_ctrl #(
    parameter int MAX_SAMPLES = 128
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  smr_pkg::t_status i_status,
    output smr_pkg::t_cmd    o_cmd
);

    localparam int SQ_W   = 31 + $clog2(MAX_SAMPLES);
    localparam int ITER_W = $clog2(SQ_W);

    smr_pkg::t_state r_state, n_state;
    logic [ITER_W-1:0] r_iter, n_iter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smr_pkg::ST_RUN;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            smr_pkg::ST_RUN: begin
                if (i_status.last_in_stage) n_state = smr_pkg::ST_START;
            end
            smr_pkg::ST_START:      n_state = smr_pkg::ST_DIV;
            smr_pkg::ST_DIV: begin
                if (r_iter == '0) n_state = smr_pkg::ST_ROOT_START;
            end
            smr_pkg::ST_ROOT_START: n_state = smr_pkg::ST_ROOT;
            smr_pkg::ST_ROOT: begin
                if (r_iter == '0) n_state = smr_pkg::ST_LOAD;
            end
            smr_pkg::ST_LOAD: begin
                if (i_status.out_free) n_state = smr_pkg::ST_RUN;
            end
            default:                n_state = smr_pkg::ST_RUN;
        endcase
    end

    // step counter
    always_comb begin
        n_iter = r_iter;
        case (r_state)
            smr_pkg::ST_START:      n_iter = ITER_W'(SQ_W - 1);
            smr_pkg::ST_ROOT_START: n_iter = ITER_W'(smr_pkg::ROOT_W - 1);
            smr_pkg::ST_DIV,
            smr_pkg::ST_ROOT:       n_iter = r_iter - 1'b1;
            default:                n_iter = r_iter;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        case (r_state)
            smr_pkg::ST_RUN:        o_cmd.ready     = !i_status.last_in_stage;
            smr_pkg::ST_START:      o_cmd.load_div  = 1'b1;
            smr_pkg::ST_DIV:        o_cmd.step_div  = 1'b1;
            smr_pkg::ST_ROOT_START: o_cmd.load_root = 1'b1;
            smr_pkg::ST_ROOT:       o_cmd.step_root = 1'b1;
            smr_pkg::ST_LOAD:       o_cmd.load_out  = i_status.out_free;
            default:                o_cmd           = '0;
        endcase
    end

    a_ready_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.ready |-> r_state == smr_pkg::ST_RUN)
        else $error("ready outside run state");

    a_div_to_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == smr_pkg::ST_DIV && r_iter == '0) |=> r_state == smr_pkg::ST_ROOT_START)
        else $error("divide did not hand over to root");

    a_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == smr_pkg::ST_START |=> (r_state == smr_pkg::ST_DIV
                                          && r_iter == ITER_W'(SQ_W - 1)))
        else $error("divide started with wrong step count");

endmodule

>>> src/smr_datapath.sv
// Accumulators, restoring dividers, square root unit and result register.
module smr_datapath #(
    parameter int MAX_SAMPLES = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic signed [smr_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_last,
    input  logic                                i_out_ready,
    input  smr_pkg::t_cmd                       i_cmd,
    output smr_pkg::t_status                    o_status,
    output logic                                o_valid,
    output logic signed [smr_pkg::MEAN_W-1:0]   o_mean,
    output logic        [smr_pkg::ROOT_W-1:0]   o_rms,
    output logic        [smr_pkg::COUNT_W-1:0]  o_count,
    output logic                                o_too_many
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = smr_pkg::SAMPLE_W + $clog2(MAX_SAMPLES);
    localparam int SQ_W  = smr_pkg::PROD_W + $clog2(MAX_SAMPLES);

    // input stage: square the sample
    logic                                r_p_valid;
    logic                                r_p_last;
    logic signed [smr_pkg::SAMPLE_W-1:0] r_p_sample;
    logic        [smr_pkg::PROD_W-1:0]   r_p_sq;
    logic signed [2*smr_pkg::SAMPLE_W-1:0] w_prod;

    assign w_prod = i_sample * i_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_p_last  <= 1'b0;
        end else begin
            r_p_valid <= i_accept;
            r_p_last  <= i_accept && i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_p_sample <= i_sample;
            r_p_sq     <= w_prod[smr_pkg::PROD_W-1:0];
        end
    end

    // accumulators
    logic signed [SUM_W-1:0] r_sum;
    logic        [SQ_W-1:0]  r_sq;
    logic        [CNT_W-1:0] r_cnt;
    logic                    r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load_div) begin
            r_sum <= '0;
            r_sq  <= '0;
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (r_p_valid) begin
            if (r_cnt == CNT_W'(MAX_SAMPLES)) begin
                r_ovf <= 1'b1;
            end else begin
                r_sum <= r_sum + SUM_W'(r_p_sample);
                r_sq  <= r_sq + SQ_W'(r_p_sq);
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // dividers: magnitude of the sum and the square sum, both by the count
    logic [SUM_W-1:0] w_sum_mag;
    logic [CNT_W-1:0] r_div;
    logic             r_neg;
    logic             r_res_ovf;
    logic [SQ_W-1:0]  r_dq_sum, r_dq_sq;
    logic [CNT_W-1:0] r_dr_sum, r_dr_sq;
    logic [CNT_W:0]   w_sh_sum, w_sh_sq;
    logic             w_bit_sum, w_bit_sq;

    assign w_sum_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign w_sh_sum  = {r_dr_sum, r_dq_sum[SQ_W-1]};
    assign w_sh_sq   = {r_dr_sq,  r_dq_sq[SQ_W-1]};
    assign w_bit_sum = w_sh_sum >= {1'b0, r_div};
    assign w_bit_sq  = w_sh_sq  >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_div) begin
            r_div     <= r_cnt;
            r_neg     <= r_sum[SUM_W-1];
            r_res_ovf <= r_ovf;
            r_dq_sum  <= SQ_W'(w_sum_mag);
            r_dq_sq   <= r_sq;
            r_dr_sum  <= '0;
            r_dr_sq   <= '0;
        end else if (i_cmd.step_div) begin
            r_dq_sum <= {r_dq_sum[SQ_W-2:0], w_bit_sum};
            r_dq_sq  <= {r_dq_sq[SQ_W-2:0], w_bit_sq};
            r_dr_sum <= w_bit_sum ? CNT_W'(w_sh_sum - {1'b0, r_div}) : CNT_W'(w_sh_sum);
            r_dr_sq  <= w_bit_sq  ? CNT_W'(w_sh_sq  - {1'b0, r_div}) : CNT_W'(w_sh_sq);
        end
    end

    // square root, one result bit per step
    logic [smr_pkg::ROOT_IN_W-1:0]  r_rv;
    logic [smr_pkg::ROOT_REM_W-1:0] r_rrem;
    logic [smr_pkg::ROOT_W-1:0]     r_root;
    logic [smr_pkg::ROOT_REM_W-1:0] w_rem2, w_trial;
    logic                           w_rbit;

    assign w_rem2  = {r_rrem[smr_pkg::ROOT_REM_W-3:0],
                      r_rv[smr_pkg::ROOT_IN_W-1:smr_pkg::ROOT_IN_W-2]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_rbit  = w_rem2 >= w_trial;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_root) begin
            r_rv   <= {1'b0, r_dq_sq[smr_pkg::ROOT_IN_W-2:0]};
            r_rrem <= '0;
            r_root <= '0;
        end else if (i_cmd.step_root) begin
            r_rv   <= {r_rv[smr_pkg::ROOT_IN_W-3:0], 2'b00};
            r_rrem <= w_rbit ? (w_rem2 - w_trial) : w_rem2;
            r_root <= {r_root[smr_pkg::ROOT_W-2:0], w_rbit};
        end
    end

    // result register
    logic [smr_pkg::MEAN_W-1:0]    w_mean_mag;
    logic [smr_pkg::MEAN_W-1:0]    w_mean;
    logic [CNT_W+smr_pkg::COUNT_W-1:0] w_cnt_ext;
    logic                          r_o_valid;

    assign w_mean_mag = r_dq_sum[smr_pkg::MEAN_W-1:0];
    assign w_mean     = r_neg ? (~w_mean_mag + 1'b1) : w_mean_mag;
    assign w_cnt_ext  = {{smr_pkg::COUNT_W{1'b0}}, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_mean     <= r_res_ovf ? '0 : w_mean;
            o_rms      <= r_res_ovf ? '0 : r_root;
            o_count    <= w_cnt_ext[smr_pkg::COUNT_W-1:0];
            o_too_many <= r_res_ovf;
        end
    end

    assign o_valid                = r_o_valid;
    assign o_status.last_in_stage = r_p_valid && r_p_last;
    assign o_status.out_free      = !r_o_valid || i_out_ready;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_SAMPLES))
        else $error("sample count above bound");

    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_div |-> !r_p_valid && !i_accept)
        else $error("sample in flight while totals are latched");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_o_valid || i_out_ready))
        else $error("result overwritten before transfer");

endmodule

>>> src/signal_mean_rms.sv
// Top level: mean and RMS of runs of Q8.8 samples.
// Throughput: one sample per cycle within a run; each run ends with a
// divide, root and result-load phase during which no sample is taken.
// Result path: the last sample is followed by the bit-serial dividers
// (SQ_W steps) and the 16-step square root; the result register holds each
// result until it is taken, so the next run can start meanwhile.
// Reset: synchronous, active low; clears totals, sequencer and result valid.
module signal_mean_rms #(
    parameter int MAX_SAMPLES = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // sample channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [smr_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_last,
    // result channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [smr_pkg::MEAN_W-1:0]   o_mean,
    output logic        [smr_pkg::ROOT_W-1:0]   o_rms,
    output logic        [smr_pkg::COUNT_W-1:0]  o_count,
    output logic                                o_too_many
);

    smr_pkg::t_cmd    w_cmd;
    smr_pkg::t_status w_status;
    logic             w_accept;

    // a sample transaction completes when both sides agree
    assign o_ready  = w_cmd.ready;
    assign w_accept = i_valid && w_cmd.ready;

    // sequencer: run, divide, root, hand result to the output register
    smr_ctrl #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // arithmetic and the result register
    smr_datapath #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_sample    (i_sample),
        .i_last      (i_last),
        .i_out_ready (i_ready),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_valid     (o_valid),
        .o_mean      (o_mean),
        .o_rms       (o_rms),
        .o_count     (o_count),
        .o_too_many  (o_too_many)
    );

endmodule
